// File: hdl/mtdt_pkg.sv
// ----------------------------------------------------------------------------
// mtdt_pkg: shared types and constants for the timer deadline table
// Operation codes, scan packet and cell control structs, wrap-aware compare.
// ----------------------------------------------------------------------------
`default_nettype none

package mtdt_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int TIME_W   = 32;

    localparam logic [KIND_W-1:0] KIND_ARM    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISARM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    // operation broadcast to every cell on an accepted input beat
    typedef struct packed {
        logic              arm;
        logic              disarm;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] expire;
    } cell_op_t;

    // scan token handed from cell to cell, carries the running minimum
    typedef struct packed {
        logic              valid;
        logic              have;
        logic [TIME_W-1:0] best;
    } scan_pkt_t;

    // true when time a is at or after time b, modulo 2^32
    function automatic logic at_or_after(input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return ~diff[TIME_W-1];
    endfunction

endpackage

`default_nettype wire

// File: hdl/mtdt_cell.sv
// ----------------------------------------------------------------------------
// mtdt_cell: one timer slot of the deadline chain
// Holds expiry and running flag, tests the passing scan token for expiry and
// folds its deadline into the token's running minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module mtdt_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       advance,
    input  wire logic [mtdt_pkg::TIME_W-1:0] now,
    input  wire mtdt_pkg::cell_op_t         op,
    input  wire mtdt_pkg::scan_pkt_t        pkt_in,
    output mtdt_pkg::scan_pkt_t             pkt_out,
    output logic                            fire
);

    logic                        running_reg;
    logic                        running_next;
    logic [mtdt_pkg::TIME_W-1:0] expiry_reg;
    logic [mtdt_pkg::TIME_W-1:0] expiry_next;
    mtdt_pkg::scan_pkt_t         pkt_reg;
    mtdt_pkg::scan_pkt_t         pkt_next;
    logic                        hit;

    assign hit  = (32'(op.slot) == CELL_IDX);
    assign fire = pkt_in.valid && running_reg && mtdt_pkg::at_or_after(now, expiry_reg);

    always_comb begin
        running_next = running_reg;
        expiry_next  = expiry_reg;
        pkt_next     = pkt_in;
        if (op.arm && hit) begin
            running_next = 1'b1;
            expiry_next  = op.expire;
        end else if (op.disarm && hit) begin
            running_next = 1'b0;
        end
        if (advance && pkt_in.valid) begin
            if (fire) begin
                running_next = 1'b0;
            end else if (running_reg) begin
                if (!pkt_in.have || !mtdt_pkg::at_or_after(expiry_reg, pkt_in.best)) begin
                    pkt_next.have = 1'b1;
                    pkt_next.best = expiry_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= 1'b0;
            pkt_reg.valid <= 1'b0;
        end else begin
            running_reg <= running_next;
            if (advance) begin
                pkt_reg <= pkt_next;
            end
        end
        expiry_reg <= expiry_next;
    end

    assign pkt_out = pkt_reg;

endmodule

`default_nettype wire

// File: hdl/multi_timer_deadline_table_top.sv
// ----------------------------------------------------------------------------
// multi_timer_deadline_table_top: timer slot table with next-deadline search
// Applies arm/disarm/tick, then scans the slot chain, reports expired slots
// and closes each run with the wait until the nearest remaining deadline.
// ----------------------------------------------------------------------------
// Each input beat applies its operation in the cycle it is taken, then a scan
// token walks the row of TIMER_SLOTS cells, one cell per cycle while the
// output is not stalled. A cell whose slot has expired clears itself and sends
// one fire beat; the token then leaves the last cell carrying the earliest
// remaining deadline, and the summary beat (tlast high) is loaded. Any output
// stall freezes the whole chain. A new item is taken as soon as its summary
// has been loaded, even while that beat is still waiting.
`default_nettype none

module multi_timer_deadline_table_top #(
    parameter int TIMER_SLOTS = mtdt_pkg::TIMER_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // slot[3:0], expire[35:4], now[67:36], zero
    input  wire logic [1:0]  s_tuser,  // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // fired_slot[3:0], next_wait[35:4], zero
    output logic [0:0]       m_tuser,  // is_fired[0]
    output logic             m_tlast
);

    localparam int TW = mtdt_pkg::TIME_W;
    localparam int SW = mtdt_pkg::SLOT_W;

    logic                      s_accept;
    logic                      advance;
    mtdt_pkg::cell_op_t        op;
    mtdt_pkg::scan_pkt_t       chain [TIMER_SLOTS+1];
    logic [TIMER_SLOTS-1:0]    fire_vec;
    logic [TIMER_SLOTS-1:0]    tok_vec;
    logic [SW-1:0]             fire_slot;
    logic [TW-1:0]             summary_wait;

    logic                      busy_reg,  busy_next;
    logic                      start_reg, start_next;
    logic [TW-1:0]             now_reg,   now_next;
    logic                      m_valid_reg, m_valid_next;
    logic [SW-1:0]             m_slot_reg,  m_slot_next;
    logic [TW-1:0]             m_wait_reg,  m_wait_next;
    logic                      m_fired_reg, m_fired_next;
    logic                      m_last_reg,  m_last_next;

    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign advance  = !m_valid_reg || m_tready;

    assign op.arm    = s_accept && (s_tuser == mtdt_pkg::KIND_ARM);
    assign op.disarm = s_accept && (s_tuser == mtdt_pkg::KIND_DISARM);
    assign op.slot   = s_tdata[3:0];
    assign op.expire = s_tdata[35:4];

    assign chain[0].valid = start_reg;
    assign chain[0].have  = 1'b0;
    assign chain[0].best  = '0;

    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        mtdt_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .now     (now_reg),
            .op      (op),
            .pkt_in  (chain[i]),
            .pkt_out (chain[i+1]),
            .fire    (fire_vec[i])
        );
        assign tok_vec[i] = chain[i+1].valid;
    end

    // at most one cell sees the token, so an and-or select is enough
    always_comb begin
        fire_slot = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            fire_slot = fire_slot | (fire_vec[i] ? SW'(i) : '0);
        end
    end

    assign summary_wait = (chain[TIMER_SLOTS].have && chain[TIMER_SLOTS].best != '0)
                        ? (chain[TIMER_SLOTS].best - now_reg) : '0;

    always_comb begin
        busy_next    = busy_reg;
        start_next   = start_reg;
        now_next     = now_reg;
        m_valid_next = m_valid_reg;
        m_slot_next  = m_slot_reg;
        m_wait_next  = m_wait_reg;
        m_fired_next = m_fired_reg;
        m_last_next  = m_last_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            start_next = 1'b0;
            if (|fire_vec) begin
                m_valid_next = 1'b1;
                m_slot_next  = fire_slot;
                m_wait_next  = '0;
                m_fired_next = 1'b1;
                m_last_next  = 1'b0;
            end else if (chain[TIMER_SLOTS].valid) begin
                m_valid_next = 1'b1;
                m_slot_next  = '0;
                m_wait_next  = summary_wait;
                m_fired_next = 1'b0;
                m_last_next  = 1'b1;
                busy_next    = 1'b0;
            end
        end
        if (s_accept) begin
            busy_next  = 1'b1;
            start_next = 1'b1;
            now_next   = s_tdata[67:36];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        now_reg     <= now_next;
        m_slot_reg  <= m_slot_next;
        m_wait_reg  <= m_wait_next;
        m_fired_reg <= m_fired_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {4'b0, m_wait_reg, m_slot_reg};
    assign m_tuser[0] = m_fired_reg;
    assign m_tlast    = m_last_reg;

    // only one scan token is ever in flight
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({tok_vec, start_reg}))
        else $error("more than one scan token in the chain");

    a_one_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(fire_vec))
        else $error("two cells fired in one cycle");

    a_start_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> start_reg && busy_reg)
        else $error("scan did not start after an accepted beat");

    a_no_accept_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_reg || (|tok_vec)) |-> !s_tready)
        else $error("input ready while a scan is in flight");

endmodule

`default_nettype wire
